// ===== sv/pwmss_pkg.sv =====
// ----------------------------------------------------------------------------
// pwmss_pkg
// Constants, codes and saturating arithmetic helpers for the position weight
// matrix scanner.
// ----------------------------------------------------------------------------
package pwmss_pkg;

	localparam int MOTIF_LEN = 32;
	localparam int COL_W     = $clog2(MOTIF_LEN);
	localparam int RAW_W     = 21;
	localparam int SCL_W     = 15;
	localparam int TRAW_W    = 16;
	localparam int TSCL_W    = 10;
	localparam int POS_W     = 32;
	localparam int LEN_W     = 6;
	localparam int ADDR_W    = 4;
	localparam int DATA_W    = 32;
	localparam int SDATA_W   = 48;
	localparam int MDATA_W   = 72;

	// Register indexes on paddr[3:2].
	localparam logic [1:0] REG_MIN_RAW    = 2'd0;
	localparam logic [1:0] REG_MIN_SCALED = 2'd1;
	localparam logic [1:0] REG_MOTIF_LEN  = 2'd2;

	// Request kinds carried in tuser[0].
	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_SEQ  = 1'b1;

	// Base codes.
	localparam logic [1:0] BASE_A = 2'd0;
	localparam logic [1:0] BASE_C = 2'd1;
	localparam logic [1:0] BASE_G = 2'd2;
	localparam logic [1:0] BASE_T = 2'd3;

	localparam logic [7:0] CHAR_UA = 8'h41;
	localparam logic [7:0] CHAR_LA = 8'h61;
	localparam logic [7:0] CHAR_UC = 8'h43;
	localparam logic [7:0] CHAR_LC = 8'h63;
	localparam logic [7:0] CHAR_UG = 8'h47;
	localparam logic [7:0] CHAR_LG = 8'h67;
	localparam logic [7:0] CHAR_UT = 8'h54;
	localparam logic [7:0] CHAR_LT = 8'h74;

	localparam logic signed [RAW_W-1:0] RAW_MAX = {1'b0, {(RAW_W-1){1'b1}}};
	localparam logic signed [RAW_W-1:0] RAW_MIN = {1'b1, {(RAW_W-1){1'b0}}};
	localparam logic [SCL_W-1:0]        SCL_MAX = {SCL_W{1'b1}};

	typedef struct packed {
		logic       valid;
		logic [1:0] code;
	} base_t;

	function automatic base_t decode_base(input logic [7:0] c);
		base_t r;
		r.valid = 1'b1;
		r.code  = BASE_A;
		case (c)
			CHAR_UA, CHAR_LA: r.code = BASE_A;
			CHAR_UC, CHAR_LC: r.code = BASE_C;
			CHAR_UG, CHAR_LG: r.code = BASE_G;
			CHAR_UT, CHAR_LT: r.code = BASE_T;
			default: r.valid = 1'b0;
		endcase
		return r;
	endfunction

	function automatic logic signed [RAW_W-1:0] sat_raw_add(
		input logic signed [RAW_W-1:0]  p,
		input logic signed [TRAW_W-1:0] t
	);
		logic signed [RAW_W:0] s;
		s = {p[RAW_W-1], p} + {{(RAW_W+1-TRAW_W){t[TRAW_W-1]}}, t};
		if (s[RAW_W] != s[RAW_W-1]) begin
			return s[RAW_W] ? RAW_MIN : RAW_MAX;
		end
		return s[RAW_W-1:0];
	endfunction

	function automatic logic [SCL_W-1:0] sat_scl_add(
		input logic [SCL_W-1:0]  p,
		input logic [TSCL_W-1:0] t
	);
		logic [SCL_W:0] s;
		s = {1'b0, p} + {{(SCL_W+1-TSCL_W){1'b0}}, t};
		return s[SCL_W] ? SCL_MAX : s[SCL_W-1:0];
	endfunction

endpackage

// ===== sv/pwm_sliding_window_scanner_core.sv =====
// ----------------------------------------------------------------------------
// pwm_sliding_window_scanner_core
// Scans a DNA byte stream against a position weight matrix and reports every
// complete window with its raw and scaled sums and a hit flag.
// ----------------------------------------------------------------------------
// Usage:
// The slave stream carries requests. tuser[0] selects a matrix load (0) or a
// sequence byte (1); tuser[1] starts a new sequence before that byte. A load
// writes one matrix cell; loads and bytes may be mixed freely. A byte that is
// not A, C, G or T (either case) breaks the run of valid bases.
// The master stream carries one result for each window of motif_length valid
// bases: start index, raw sum, scaled sum in tdata and the hit flag in tuser.
// Throughput is one request per cycle while no window result waits behind a
// full output register. A request is registered on acceptance and evaluated
// from the input register against the partial-sum row, where every column
// adds its matrix cell in parallel; its result is loaded into the output
// register, which drives m_tvalid, as the request leaves the input register.
// When the receiver stalls, the output register holds its result
// and the input register holds the next request, so s_tready drops only once
// a request that completes a window waits behind a full output register.
// Reset clears the partial sums, the run length, the position counter and
// the registers (min_raw_score to its most negative value, min_scaled_score
// to 0, motif_length to 32). Matrix cells are undefined until loaded. The
// user must write configuration via the APB port with stream idle, unchecked.
// ----------------------------------------------------------------------------
module pwm_sliding_window_scanner_core (
	input  logic                          clk,
	input  logic                          arst_n,
	// tdata: symbol[7:0], entry_base[9:8], entry_offset[14:10],
	// entry_raw[30:15], entry_scaled[40:31], zero fill to 47
	input  logic                          s_tvalid,
	output logic                          s_tready,
	input  logic [pwmss_pkg::SDATA_W-1:0] s_tdata,
	// tuser: func[0], new_sequence[1]
	input  logic [1:0]                    s_tuser,
	// tdata: window_start[31:0], raw_score[52:32], scaled_score[67:53],
	// zero fill to 71
	output logic                          m_tvalid,
	input  logic                          m_tready,
	output logic [pwmss_pkg::MDATA_W-1:0] m_tdata,
	// tuser: hit[0]
	output logic [0:0]                    m_tuser,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [pwmss_pkg::ADDR_W-1:0]  paddr,
	input  logic [pwmss_pkg::DATA_W-1:0]  pwdata,
	output logic [pwmss_pkg::DATA_W-1:0]  prdata,
	output logic                          pready
);

	localparam int N     = pwmss_pkg::MOTIF_LEN;
	localparam int CW    = pwmss_pkg::COL_W;
	localparam int RW    = pwmss_pkg::RAW_W;
	localparam int SW    = pwmss_pkg::SCL_W;
	localparam int TRW   = pwmss_pkg::TRAW_W;
	localparam int TSW   = pwmss_pkg::TSCL_W;
	localparam int PW    = pwmss_pkg::POS_W;
	localparam int LW    = pwmss_pkg::LEN_W;

	// Configuration registers.
	logic signed [RW-1:0] min_raw_q;
	logic [SW-1:0]        min_scl_q;
	logic [LW-1:0]        motif_len_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_raw_q   <= pwmss_pkg::RAW_MIN;
			min_scl_q   <= '0;
			motif_len_q <= LW'(N);
		end else if (psel && penable && pwrite) begin
			case (paddr[3:2])
				pwmss_pkg::REG_MIN_RAW:    min_raw_q   <= pwdata[RW-1:0];
				pwmss_pkg::REG_MIN_SCALED: min_scl_q   <= pwdata[SW-1:0];
				pwmss_pkg::REG_MOTIF_LEN:  motif_len_q <= pwdata[LW-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			pwmss_pkg::REG_MIN_RAW:
				prdata = {{(pwmss_pkg::DATA_W-RW){min_raw_q[RW-1]}}, min_raw_q};
			pwmss_pkg::REG_MIN_SCALED:
				prdata = {{(pwmss_pkg::DATA_W-SW){1'b0}}, min_scl_q};
			pwmss_pkg::REG_MOTIF_LEN:
				prdata = {{(pwmss_pkg::DATA_W-LW){1'b0}}, motif_len_q};
			default: prdata = '0;
		endcase
	end

	// Input register.
	logic                  s1_valid_q;
	logic                  func_s1;
	logic                  new_seq_s1;
	logic [7:0]            symbol_s1;
	logic [1:0]            ebase_s1;
	logic [CW-1:0]         eoff_s1;
	logic signed [TRW-1:0] eraw_s1;
	logic [TSW-1:0]        escl_s1;

	logic s_fire;
	logic s1_adv;
	logic produce;
	logic out_load;

	assign s_tready = !s1_valid_q || s1_adv;
	assign s_fire   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_tready) begin
			s1_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_fire) begin
			func_s1    <= s_tuser[0];
			new_seq_s1 <= s_tuser[1];
			symbol_s1  <= s_tdata[7:0];
			ebase_s1   <= s_tdata[9:8];
			eoff_s1    <= s_tdata[10 +: CW];
			eraw_s1    <= s_tdata[30:15];
			escl_s1    <= s_tdata[40:31];
		end
	end

	// Scanner state. Matrix cells are grouped by base; each column picks
	// its cell for the current base.
	logic signed [TRW-1:0] raw_tab_q [0:3][0:N-1];
	logic [TSW-1:0]        scl_tab_q [0:3][0:N-1];
	logic signed [RW-1:0]  raw_part_q [0:N-1];
	logic [SW-1:0]         scl_part_q [0:N-1];
	logic [CW-1:0]         vrun_q;
	logic [PW-1:0]         pos_q;

	pwmss_pkg::base_t      bse;
	logic                  is_seq;
	logic [CW-1:0]         len_m1;
	logic [LW-1:0]         len_dec;
	logic [CW-1:0]         vrun_eff;
	logic [CW-1:0]         vrun_cap;
	logic                  full;
	logic [PW-1:0]         cur_pos;
	logic signed [TRW-1:0] col_raw [0:N-1];
	logic [TSW-1:0]        col_scl [0:N-1];
	logic signed [RW-1:0]  raw_eff [0:N-1];
	logic [SW-1:0]         scl_eff [0:N-1];
	logic signed [RW-1:0]  raw_done;
	logic [SW-1:0]         scl_done;

	assign bse     = pwmss_pkg::decode_base(symbol_s1);
	assign is_seq  = (func_s1 == pwmss_pkg::FUNC_SEQ);
	assign len_dec = motif_len_q - LW'(1);

	always_comb begin
		if (motif_len_q == '0) begin
			len_m1 = '0;
		end else if (motif_len_q > LW'(N)) begin
			len_m1 = CW'(N - 1);
		end else begin
			len_m1 = len_dec[CW-1:0];
		end
	end

	// A new sequence clears the run before the byte is looked at.
	assign vrun_eff = new_seq_s1 ? '0 : vrun_q;
	assign vrun_cap = (vrun_eff > len_m1) ? len_m1 : vrun_eff;
	assign full     = (vrun_cap == len_m1);
	assign cur_pos  = new_seq_s1 ? '0 : pos_q;

	always_comb begin
		for (int k = 0; k < N; k++) begin
			col_raw[k] = raw_tab_q[bse.code][k];
			col_scl[k] = scl_tab_q[bse.code][k];
			raw_eff[k] = new_seq_s1 ? '0 : raw_part_q[k];
			scl_eff[k] = new_seq_s1 ? '0 : scl_part_q[k];
		end
	end

	assign raw_done = pwmss_pkg::sat_raw_add(raw_eff[len_m1], col_raw[len_m1]);
	assign scl_done = pwmss_pkg::sat_scl_add(scl_eff[len_m1], col_scl[len_m1]);

	assign produce  = s1_valid_q && is_seq && bse.valid && full;
	assign s1_adv   = s1_valid_q && (!produce || !m_tvalid || m_tready);
	assign out_load = s1_adv && produce;

	always_ff @(posedge clk) begin
		if (s1_adv && !is_seq) begin
			raw_tab_q[ebase_s1][eoff_s1] <= eraw_s1;
			scl_tab_q[ebase_s1][eoff_s1] <= escl_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < N; k++) begin
				raw_part_q[k] <= '0;
				scl_part_q[k] <= '0;
			end
			vrun_q <= '0;
			pos_q  <= '0;
		end else if (s1_adv && is_seq) begin
			pos_q <= (cur_pos == '1) ? cur_pos : cur_pos + PW'(1);
			if (bse.valid) begin
				raw_part_q[0] <= '0;
				scl_part_q[0] <= '0;
				for (int k = 1; k < N; k++) begin
					raw_part_q[k] <= pwmss_pkg::sat_raw_add(raw_eff[k-1], col_raw[k-1]);
					scl_part_q[k] <= pwmss_pkg::sat_scl_add(scl_eff[k-1], col_scl[k-1]);
				end
				vrun_q <= full ? vrun_cap : vrun_cap + CW'(1);
			end else begin
				vrun_q <= '0;
				if (new_seq_s1) begin
					for (int k = 0; k < N; k++) begin
						raw_part_q[k] <= '0;
						scl_part_q[k] <= '0;
					end
				end
			end
		end
	end

	// Output register.
	logic                 m_valid_q;
	logic [PW-1:0]        wstart_q;
	logic signed [RW-1:0] oraw_q;
	logic [SW-1:0]        oscl_q;
	logic                 hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (out_load) begin
			m_valid_q <= 1'b1;
		end else if (m_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			wstart_q <= cur_pos - {{(PW-CW){1'b0}}, len_m1};
			oraw_q   <= raw_done;
			oscl_q   <= scl_done;
			hit_q    <= (raw_done >= min_raw_q) && (scl_done >= min_scl_q);
		end
	end

	assign m_tvalid   = m_valid_q;
	assign m_tdata    = {{(pwmss_pkg::MDATA_W-PW-RW-SW){1'b0}}, oscl_q, oraw_q, wstart_q};
	assign m_tuser[0] = hit_q;

	// A pending result is never overwritten before it is taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_load && m_tvalid && !m_tready))
		else $error("result register overwritten while stalled");

	// A byte that is not a base leaves the run empty.
	a_break_run: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && is_seq && !bse.valid) |=> (vrun_q == '0))
		else $error("run not cleared by non-base byte");

	// The position counter holds once saturated.
	a_pos_sat: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && is_seq && !new_seq_s1 && pos_q == '1) |=> (pos_q == '1))
		else $error("position counter wrapped");

	// A load request never raises a result.
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && !is_seq && !m_tvalid) |=> !m_tvalid)
		else $error("load request produced a result");

	// A request held in the input register is not dropped.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_valid_q && !s1_adv) |=> s1_valid_q)
		else $error("stalled request lost");

endmodule

// ===== verif/pwm_sliding_window_scanner_core_test.sv =====
// ----------------------------------------------------------------------------
// pwm_sliding_window_scanner_core_test
// Self-checking testbench for the position weight matrix scanner. A scoring
// model inside the bench follows every accepted request and queues the window
// results it should cause; each result on the master stream is compared with
// the oldest queued one. Directed requests cover matrix extremes, all base
// letters, breaks and new sequences; random phases then scan with varied window
// lengths and thresholds, the first six under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module pwm_sliding_window_scanner_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RAW_LSB = pwmss_pkg::POS_W;
	localparam int SCL_LSB = RAW_LSB + pwmss_pkg::RAW_W;
	localparam int HIT_ROWS = 10;

	typedef struct {
		logic                                func;
		logic                                new_seq;
		logic [7:0]                          symbol;
		logic [1:0]                          base;
		logic [pwmss_pkg::COL_W-1:0]         offset;
		logic signed [pwmss_pkg::TRAW_W-1:0] raw;
		logic [pwmss_pkg::TSCL_W-1:0]        scl;
	} request_t;

	typedef struct {
		logic [pwmss_pkg::POS_W-1:0]        start;
		logic signed [pwmss_pkg::RAW_W-1:0] raw;
		logic [pwmss_pkg::SCL_W-1:0]        scl;
		logic                               hit;
	} window_t;

	logic                            clk;
	logic                            arst_n;
	logic                            s_tvalid;
	logic                            s_tready;
	logic [pwmss_pkg::SDATA_W-1:0]   s_tdata;
	logic [1:0]                      s_tuser;
	logic                            m_tvalid;
	logic                            m_tready;
	logic [pwmss_pkg::MDATA_W-1:0]   m_tdata;
	logic [0:0]                      m_tuser;
	logic                            psel;
	logic                            penable;
	logic                            pwrite;
	logic [pwmss_pkg::ADDR_W-1:0]    paddr;
	logic [pwmss_pkg::DATA_W-1:0]    pwdata;
	logic [pwmss_pkg::DATA_W-1:0]    prdata;
	logic                            pready;

	// Scoring model state.
	logic signed [pwmss_pkg::RAW_W-1:0]  col_raw [pwmss_pkg::MOTIF_LEN];
	logic [pwmss_pkg::SCL_W-1:0]         col_scl [pwmss_pkg::MOTIF_LEN];
	logic signed [pwmss_pkg::TRAW_W-1:0] pwm_raw [4][pwmss_pkg::MOTIF_LEN];
	logic [pwmss_pkg::TSCL_W-1:0]        pwm_scl [4][pwmss_pkg::MOTIF_LEN];
	int                                  run_len = 0;
	logic [pwmss_pkg::POS_W-1:0]         next_pos = '0;
	logic signed [pwmss_pkg::RAW_W-1:0]  thr_raw = pwmss_pkg::RAW_MIN;
	logic [pwmss_pkg::SCL_W-1:0]         thr_scl = '0;
	logic [pwmss_pkg::LEN_W-1:0]         len_reg = pwmss_pkg::LEN_W'(pwmss_pkg::MOTIF_LEN);

	window_t pending_windows [$];

	bit idle_on = 1'b1;
	int error_count = 0;
	int request_count = 0;
	int load_count = 0;
	int window_count = 0;
	int hit_count = 0;

	logic [7:0] base_letters [8] = '{pwmss_pkg::CHAR_UA, pwmss_pkg::CHAR_LA,
		pwmss_pkg::CHAR_UC, pwmss_pkg::CHAR_LC, pwmss_pkg::CHAR_UG, pwmss_pkg::CHAR_LG,
		pwmss_pkg::CHAR_UT, pwmss_pkg::CHAR_LT};

	pwm_sliding_window_scanner_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int base_code(input logic [7:0] c);
		case (c)
			pwmss_pkg::CHAR_UA, pwmss_pkg::CHAR_LA: return int'(pwmss_pkg::BASE_A);
			pwmss_pkg::CHAR_UC, pwmss_pkg::CHAR_LC: return int'(pwmss_pkg::BASE_C);
			pwmss_pkg::CHAR_UG, pwmss_pkg::CHAR_LG: return int'(pwmss_pkg::BASE_G);
			pwmss_pkg::CHAR_UT, pwmss_pkg::CHAR_LT: return int'(pwmss_pkg::BASE_T);
			default: return -1;
		endcase
	endfunction

	function automatic int window_span();
		int n;
		n = int'(len_reg);
		if (n < 1) n = 1;
		if (n > pwmss_pkg::MOTIF_LEN) n = pwmss_pkg::MOTIF_LEN;
		return n;
	endfunction

	function automatic logic signed [pwmss_pkg::RAW_W-1:0] clip_raw(input int v);
		if (v > int'(pwmss_pkg::RAW_MAX)) return pwmss_pkg::RAW_MAX;
		if (v < int'(pwmss_pkg::RAW_MIN)) return pwmss_pkg::RAW_MIN;
		return v[pwmss_pkg::RAW_W-1:0];
	endfunction

	function automatic logic [pwmss_pkg::SCL_W-1:0] clip_scl(input int v);
		if (v > int'(pwmss_pkg::SCL_MAX)) return pwmss_pkg::SCL_MAX;
		return v[pwmss_pkg::SCL_W-1:0];
	endfunction

	// Advances the scoring model by one accepted request and queues the
	// window that it completes, if any.
	function automatic void score_request(input request_t r);
		int n;
		int b;
		int k;
		logic [pwmss_pkg::POS_W-1:0] cur;
		logic full;
		window_t w;
		if (r.func == pwmss_pkg::FUNC_LOAD) begin
			pwm_raw[r.base][r.offset] = r.raw;
			pwm_scl[r.base][r.offset] = r.scl;
			return;
		end
		n = window_span();
		if (r.new_seq) begin
			run_len = 0;
			next_pos = '0;
			for (k = 0; k < pwmss_pkg::MOTIF_LEN; k++) begin
				col_raw[k] = '0;
				col_scl[k] = '0;
			end
		end
		cur = next_pos;
		if (next_pos != '1) next_pos = next_pos + pwmss_pkg::POS_W'(1);
		b = base_code(r.symbol);
		if (b < 0) begin
			run_len = 0;
			return;
		end
		if (run_len > n - 1) run_len = n - 1;
		full = (run_len == n - 1);
		if (full) begin
			w.raw = clip_raw(int'(col_raw[n-1]) + int'(pwm_raw[b][n-1]));
			w.scl = clip_scl(int'(col_scl[n-1]) + int'(pwm_scl[b][n-1]));
		end
		for (k = pwmss_pkg::MOTIF_LEN - 1; k >= 1; k--) begin
			col_raw[k] = clip_raw(int'(col_raw[k-1]) + int'(pwm_raw[b][k-1]));
			col_scl[k] = clip_scl(int'(col_scl[k-1]) + int'(pwm_scl[b][k-1]));
		end
		col_raw[0] = '0;
		col_scl[0] = '0;
		if (!full) begin
			run_len++;
			return;
		end
		w.start = cur - pwmss_pkg::POS_W'(n - 1);
		w.hit = (w.raw >= thr_raw) && (w.scl >= thr_scl);
		pending_windows = {pending_windows, w};
	endfunction

	// Sequence byte; the unused load fields carry random bits.
	function automatic request_t byte_req(input logic [7:0] c, input logic fresh);
		request_t r;
		logic [31:0] rnd;
		rnd = $urandom();
		r.func = pwmss_pkg::FUNC_SEQ;
		r.new_seq = fresh;
		r.symbol = c;
		r.base = rnd[1:0];
		r.offset = rnd[6:2];
		r.raw = rnd[22:7];
		r.scl = 10'($urandom_range(0, 1023));
		return r;
	endfunction

	function automatic request_t load_req(input logic [1:0] b,
		input logic [pwmss_pkg::COL_W-1:0] col,
		input logic signed [pwmss_pkg::TRAW_W-1:0] raw,
		input logic [pwmss_pkg::TSCL_W-1:0] scl, input logic fresh);
		request_t r;
		r.func = pwmss_pkg::FUNC_LOAD;
		r.new_seq = fresh;
		r.symbol = 8'($urandom_range(0, 255));
		r.base = b;
		r.offset = col;
		r.raw = raw;
		r.scl = scl;
		return r;
	endfunction

	function automatic request_t random_load();
		logic [31:0] rnd;
		rnd = $urandom();
		return load_req(rnd[1:0], rnd[6:2], rnd[22:7], 10'($urandom_range(0, 1023)), rnd[23]);
	endfunction

	function automatic logic [7:0] junk_byte();
		logic [7:0] c;
		do c = 8'($urandom_range(0, 255)); while (base_code(c) >= 0);
		return c;
	endfunction

	task automatic send_request(input request_t r);
		if (idle_on && $urandom_range(0, 5) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {7'd0, r.scl, r.raw, r.offset, r.base, r.symbol};
		s_tuser <= {r.new_seq, r.func};
		do @(posedge clk); while (!s_tready);
		score_request(r);
		request_count++;
		if (r.func == pwmss_pkg::FUNC_LOAD) load_count++;
	endtask

	// Stops the stream and lets every request in flight finish.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (pending_windows.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] idx,
		input logic [pwmss_pkg::DATA_W-1:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			pwmss_pkg::REG_MIN_RAW:    thr_raw = value[pwmss_pkg::RAW_W-1:0];
			pwmss_pkg::REG_MIN_SCALED: thr_scl = value[pwmss_pkg::SCL_W-1:0];
			pwmss_pkg::REG_MOTIF_LEN:  len_reg = value[pwmss_pkg::LEN_W-1:0];
			default: ;
		endcase
	endtask

	// Column A holds the largest entries and column C the smallest, so that
	// runs of one letter reach the sum extremes.
	task automatic test_matrix_load();
		int b;
		int c;
		for (b = 0; b < 4; b++) begin
			for (c = 0; c < pwmss_pkg::MOTIF_LEN; c++) begin
				case (2'(b))
					pwmss_pkg::BASE_A: send_request(load_req(2'(b),
						pwmss_pkg::COL_W'(c), 16'sh7FFF, 10'd1023,
						1'($urandom_range(0, 1))));
					pwmss_pkg::BASE_C: send_request(load_req(2'(b),
						pwmss_pkg::COL_W'(c), 16'sh8000, 10'd0,
						1'($urandom_range(0, 1))));
					default: send_request(load_req(2'(b), pwmss_pkg::COL_W'(c),
						16'($urandom_range(0, 65535)), 10'($urandom_range(0, 1023)),
						1'($urandom_range(0, 1))));
				endcase
			end
		end
	endtask

	task automatic test_short_windows();
		int i;
		settle();
		write_reg(pwmss_pkg::REG_MOTIF_LEN, 32'd4);
		send_request(byte_req(pwmss_pkg::CHAR_UA, 1'b1));
		send_request(byte_req(pwmss_pkg::CHAR_LA, 1'b0));
		send_request(byte_req(pwmss_pkg::CHAR_UA, 1'b0));
		send_request(byte_req(pwmss_pkg::CHAR_LA, 1'b0));
		send_request(byte_req(pwmss_pkg::CHAR_UC, 1'b0));
		send_request(byte_req(pwmss_pkg::CHAR_LC, 1'b0));
		for (i = 4; i < 8; i++) send_request(byte_req(base_letters[i], 1'b0));
		// Byte extremes are not bases and break the run.
		send_request(byte_req(8'h00, 1'b0));
		send_request(byte_req(8'hFF, 1'b0));
		// A load ignores the new-sequence flag.
		send_request(load_req(pwmss_pkg::BASE_G, '0, 16'($urandom_range(0, 65535)),
			10'd1000, 1'b1));
		send_request(byte_req(pwmss_pkg::CHAR_UA, 1'b0));
		send_request(byte_req(pwmss_pkg::CHAR_UC, 1'b0));
		send_request(byte_req(pwmss_pkg::CHAR_UG, 1'b0));
		// New sequence in the middle of a run restarts the position at zero.
		send_request(byte_req(pwmss_pkg::CHAR_UT, 1'b1));
		send_request(byte_req(pwmss_pkg::CHAR_LA, 1'b0));
		send_request(load_req(pwmss_pkg::BASE_T, '1, 16'sh0100, 10'd512, 1'b0));
		send_request(byte_req(pwmss_pkg::CHAR_LC, 1'b0));
		send_request(byte_req(pwmss_pkg::CHAR_LG, 1'b0));
	endtask

	task automatic test_length_bounds();
		settle();
		write_reg(pwmss_pkg::REG_MOTIF_LEN, 32'd0);
		send_request(byte_req(pwmss_pkg::CHAR_UT, 1'b0));
		send_request(byte_req(pwmss_pkg::CHAR_LA, 1'b0));
		settle();
		write_reg(pwmss_pkg::REG_MOTIF_LEN, 32'd63);
		send_request(byte_req(pwmss_pkg::CHAR_LG, 1'b0));
		send_request(byte_req(pwmss_pkg::CHAR_UC, 1'b0));
	endtask

	// Random phases, each with its own length and thresholds. Runs carry over
	// from one phase to the next, so a length change lands in the middle of a run.
	task automatic test_random_scan();
		int p;
		int i;
		int n;
		int lim;
		int sel;
		int brk;
		logic signed [pwmss_pkg::RAW_W-1:0] raw_thr;
		for (i = 0; i < 4 * pwmss_pkg::MOTIF_LEN; i++) send_request(random_load());
		for (p = 0; p < 8; p++) begin
			settle();
			idle_on = (p < 6);
			case (p)
				0: write_reg(pwmss_pkg::REG_MOTIF_LEN, 32'd32);
				1: write_reg(pwmss_pkg::REG_MOTIF_LEN, 32'd1);
				2: write_reg(pwmss_pkg::REG_MOTIF_LEN, 32'd63);
				3: write_reg(pwmss_pkg::REG_MOTIF_LEN, 32'd0);
				4: write_reg(pwmss_pkg::REG_MOTIF_LEN, 32'd2);
				default: write_reg(pwmss_pkg::REG_MOTIF_LEN, 32'($urandom_range(3, 16)));
			endcase
			n = window_span();
			lim = n * 10000;
			raw_thr = clip_raw(int'($urandom_range(0, 2 * lim)) - lim);
			if (p == 0) raw_thr = pwmss_pkg::RAW_MIN;
			if (p == 1) raw_thr = pwmss_pkg::RAW_MAX;
			write_reg(pwmss_pkg::REG_MIN_RAW, pwmss_pkg::DATA_W'(raw_thr));
			case (p)
				0: write_reg(pwmss_pkg::REG_MIN_SCALED, 32'd0);
				2: write_reg(pwmss_pkg::REG_MIN_SCALED, 32'(pwmss_pkg::SCL_MAX));
				default: write_reg(pwmss_pkg::REG_MIN_SCALED,
					32'($urandom_range(0, n * 700)));
			endcase
			// Long windows need long unbroken runs.
			brk = (n > 8) ? 2 : 8;
			for (i = 0; i < 115; i++) begin
				sel = $urandom_range(0, 99);
				if (sel < brk)
					send_request(byte_req(junk_byte(), 1'($urandom_range(0, 3) == 0)));
				else if (sel < 2 * brk)
					send_request(byte_req(base_letters[$urandom_range(0, 7)], 1'b1));
				else if (sel < 2 * brk + 8)
					send_request(random_load());
				else
					send_request(byte_req(base_letters[$urandom_range(0, 7)], 1'b0));
			end
		end
	endtask

	initial begin
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 9)) @(posedge clk);
			end
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		window_t want;
		logic [pwmss_pkg::POS_W-1:0] got_start;
		logic signed [pwmss_pkg::RAW_W-1:0] got_raw;
		logic [pwmss_pkg::SCL_W-1:0] got_scl;
		logic got_hit;
		if (arst_n && m_tvalid && m_tready) begin
			got_start = m_tdata[pwmss_pkg::POS_W-1:0];
			got_raw = m_tdata[RAW_LSB +: pwmss_pkg::RAW_W];
			got_scl = m_tdata[SCL_LSB +: pwmss_pkg::SCL_W];
			got_hit = m_tuser[0];
			window_count++;
			if (got_hit) hit_count++;
			if (pending_windows.size() == 0) begin
				error_count++;
				if (error_count <= HIT_ROWS)
					$display("ERROR: result with none expected: start %0d raw %0d scaled %0d hit %0b",
						got_start, got_raw, got_scl, got_hit);
			end else begin
				want = pending_windows.pop_front();
				if (got_start !== want.start || got_raw !== want.raw ||
						got_scl !== want.scl || got_hit !== want.hit) begin
					error_count++;
					if (error_count <= HIT_ROWS) begin
						$display("ERROR: expected start %0d raw %0d scaled %0d hit %0b",
							want.start, want.raw, want.scl, want.hit);
						$display("       got      start %0d raw %0d scaled %0d hit %0b",
							got_start, got_raw, got_scl, got_hit);
					end
				end
			end
		end
	end

	initial begin
		int waited;
		arst_n <= 1'b0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tuser <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		for (int k = 0; k < pwmss_pkg::MOTIF_LEN; k++) begin
			col_raw[k] = '0;
			col_scl[k] = '0;
		end
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		test_matrix_load();
		test_short_windows();
		test_length_bounds();
		test_random_scan();

		s_tvalid <= 1'b0;
		waited = 0;
		while (pending_windows.size() != 0 && waited < 2000) begin
			@(posedge clk);
			waited++;
		end
		repeat (8) @(posedge clk);
		if (pending_windows.size() != 0) begin
			error_count += pending_windows.size();
			$display("ERROR: %0d expected windows never arrived", pending_windows.size());
		end
		$display("Scanned %0d requests (%0d matrix loads) and checked %0d windows, %0d hits.",
			request_count, load_count, window_count, hit_count);
		$display("Window lengths 0 to 63 and both threshold extremes were exercised.");
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("ERROR: simulation timed out");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/pwmss_pkg.sv
sv/pwm_sliding_window_scanner_core.sv
verif/pwm_sliding_window_scanner_core_test.sv
